@@ sv/itarf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII radix formatter: shared definitions
// Base codes, the per-number flag word, the back-end state type, character
// constants and the digit to character lookup.
// ----------------------------------------------------------------------------
package itarf_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 30;
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Encodings of the base_sel input field.
  localparam logic [1:0] BSEL_OCT = 2'd0;
  localparam logic [1:0] BSEL_DEC = 2'd1;
  localparam logic [1:0] BSEL_HEX = 2'd2;

  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_X_LO   = 8'h78;

  typedef enum logic [1:0] {
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_e;

  typedef struct packed {
    logic  neg;
    base_e base;
    logic  pad_zero;
    logic  show_prefix;
    logic  upper;
  } flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_DIGIT
  } state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [3:0] ofs;
    ofs = d - 4'd10;
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end else if (upper) begin
      return CH_A_UP + {4'd0, ofs};
    end else begin
      return CH_A_LO + {4'd0, ofs};
    end
  endfunction

endpackage

@@ sv/integer_to_ascii_radix_formatter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII radix formatter
// Formats one number per input word into ASCII characters, one character
// per output word, with the final character of each number marked.
// ----------------------------------------------------------------------------
//  Channel  | Handshake           | Word
//  ---------+---------------------+-------------------------------------------
//  input    | push_i / full_o     | value, is_signed, base_sel, min_digits,
//           |                     | pad_zero, show_prefix, uppercase
//  result   | empty_o / pop_i     | char_out, last_char
//
// A number is loaded from the input queue; in decimal the shift-and-add-3
// converter then takes its bits two a cycle; leading zero positions below
// (VALUE_BITS+2)/3 and at or above both the minimum count and the number's
// own digit count are skipped, and the characters are sent one a cycle while
// the result queue has room.
// A two-word queue sits between front and back end, another on the result
// side, so either side may stall without stopping the other.
// Reset is asynchronous and empties both queues and the converter.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_formatter_unit #(
  parameter int unsigned MAX_DIGITS = itarf_pkg::MAX_DIGITS_DEF,
  parameter int unsigned VALUE_BITS = itarf_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [63:0] value_i,
  input  logic        is_signed_i,
  input  logic [1:0]  base_sel_i,
  input  logic [4:0]  min_digits_i,
  input  logic        pad_zero_i,
  input  logic        show_prefix_i,
  input  logic        uppercase_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  char_out_o,
  output logic        last_char_o
);
  import itarf_pkg::*;

  localparam int unsigned MIND_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned FLG_W  = $bits(flags_t);
  localparam int unsigned Q_W    = VALUE_BITS + MIND_W + FLG_W;

  logic [VALUE_BITS-1:0] f_mag, b_mag;
  logic [MIND_W-1:0]     f_mind, b_mind;
  flags_t                f_flags, b_flags;
  logic [Q_W-1:0]        q_rdata;
  logic                  q_empty, q_pop;
  logic                  o_full, o_push;
  logic [7:0]            o_char;
  logic                  o_last;

  itarf_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .value_i       (value_i),
    .is_signed_i   (is_signed_i),
    .base_sel_i    (base_sel_i),
    .min_digits_i  (min_digits_i),
    .pad_zero_i    (pad_zero_i),
    .show_prefix_i (show_prefix_i),
    .uppercase_i   (uppercase_i),
    .mag_o         (f_mag),
    .mind_o        (f_mind),
    .flags_o       (f_flags)
  );

  itarf_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i ({f_mag, f_mind, f_flags}),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign b_mag   = q_rdata[Q_W-1 -: VALUE_BITS];
  assign b_mind  = q_rdata[FLG_W +: MIND_W];
  assign b_flags = flags_t'(q_rdata[FLG_W-1:0]);

  itarf_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_empty_i (q_empty),
    .in_pop_o   (q_pop),
    .mag_i      (b_mag),
    .mind_i     (b_mind),
    .flags_i    (b_flags),
    .out_full_i (o_full),
    .out_push_o (o_push),
    .char_o     (o_char),
    .last_o     (o_last)
  );

  itarf_fifo #(
    .WIDTH (9),
    .DEPTH (QUEUE_DEPTH)
  ) u_char_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .wdata_i ({o_last, o_char}),
    .full_o  (o_full),
    .pop_i   (pop_i),
    .rdata_o ({last_char_o, char_out_o}),
    .empty_o (empty_o)
  );

endmodule

@@ sv/itarf_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small word queue
// A shallow first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module itarf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ sv/itarf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter front end
// Classifies an incoming number: sign and magnitude, base, saturated
// minimum digit count and formatting flags.
// ----------------------------------------------------------------------------
module itarf_front #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_DIGITS = 30
) (
  input  logic [63:0]                      value_i,
  input  logic                             is_signed_i,
  input  logic [1:0]                       base_sel_i,
  input  logic [4:0]                       min_digits_i,
  input  logic                             pad_zero_i,
  input  logic                             show_prefix_i,
  input  logic                             uppercase_i,
  output logic [VALUE_BITS-1:0]            mag_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0]  mind_o,
  output itarf_pkg::flags_t                flags_o
);
  import itarf_pkg::*;

  localparam int unsigned MIND_W = $clog2(MAX_DIGITS + 1);

  logic [VALUE_BITS-1:0] v;
  logic                  neg;

  assign v   = value_i[VALUE_BITS-1:0];
  assign neg = is_signed_i && v[VALUE_BITS-1];

  // The most negative value negates onto itself, which is its exact magnitude.
  assign mag_o = neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;

  always_comb begin
    if (int'(min_digits_i) > int'(MAX_DIGITS)) begin
      mind_o = MIND_W'(MAX_DIGITS);
    end else begin
      mind_o = MIND_W'(min_digits_i);
    end
  end

  always_comb begin
    flags_o.neg         = neg;
    flags_o.pad_zero    = pad_zero_i;
    flags_o.show_prefix = show_prefix_i;
    flags_o.upper       = uppercase_i;
    // The unused selector code is taken as hexadecimal.
    unique case (base_sel_i)
      BSEL_OCT: flags_o.base = BASE_OCT;
      BSEL_DEC: flags_o.base = BASE_DEC;
      default:  flags_o.base = BASE_HEX;
    endcase
  end

endmodule

@@ sv/itarf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter back end
// Converts a classified number into digits and sends sign, prefix, padding and
// digits out most significant first, one character a cycle when the output has room.
// ----------------------------------------------------------------------------
module itarf_back #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_DIGITS = 30
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_empty_i,
  output logic                             in_pop_o,
  input  logic [VALUE_BITS-1:0]            mag_i,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]  mind_i,
  input  itarf_pkg::flags_t                flags_i,
  input  logic                             out_full_i,
  output logic                             out_push_o,
  output logic [7:0]                       char_o,
  output logic                             last_o
);
  import itarf_pkg::*;

  localparam int unsigned MIND_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned POS_W  = $clog2(MAX_DIGITS);
  // Octal needs the most digits; decimal and hex fit in as many.
  localparam int unsigned NDIG   = (VALUE_BITS + 2) / 3;
  localparam int unsigned IDX_W  = $clog2(NDIG);
  localparam int unsigned DIG_W  = 4 * NDIG;
  localparam int unsigned SH_W   = VALUE_BITS + (VALUE_BITS % 2);
  localparam int unsigned STEPS  = SH_W / 2;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  state_e              state_q, state_d;
  logic [DIG_W-1:0]    dig_q, dig_d;
  logic [SH_W-1:0]     sh_q, sh_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                seen_q, seen_d;
  logic [MIND_W-1:0]   mind_q, mind_d;
  flags_t              flags_q, flags_d;

  logic [DIG_W-1:0]    ext, oct_dig;
  logic [3:0]          cur_dig;
  logic                cur_zero, lead, skip;
  logic [7:0]          pad_char;

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic logic [DIG_W-1:0] dabble(input logic [DIG_W-1:0] b, input logic bit_in);
    logic [DIG_W-1:0] t;
    t = b;
    for (int i = 0; i < int'(NDIG); i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[DIG_W-2:0], bit_in};
  endfunction

  function automatic state_e after_conv(input flags_t f);
    if (f.neg) begin
      return ST_SIGN;
    end else if (f.show_prefix && (f.base != BASE_DEC)) begin
      return ST_PFX0;
    end else begin
      return ST_DIGIT;
    end
  endfunction

  assign ext = DIG_W'(mag_i);

  always_comb begin
    for (int k = 0; k < int'(NDIG); k++) begin
      oct_dig[4*k +: 4] = {1'b0, ext[3*k +: 3]};
    end
  end

  assign cur_dig  = (pos_q < POS_W'(NDIG)) ? dig_q[4*pos_q[IDX_W-1:0] +: 4] : 4'd0;
  assign cur_zero = (cur_dig == 4'd0);
  // A leading zero above the lowest position is padding or is dropped.
  assign lead     = !seen_q && cur_zero && (pos_q != '0);
  assign skip     = lead && (MIND_W'(pos_q) >= mind_q);
  assign pad_char = flags_q.pad_zero ? CH_ZERO : CH_SPACE;

  always_comb begin
    state_d    = state_q;
    dig_d      = dig_q;
    sh_d       = sh_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    seen_d     = seen_q;
    mind_d     = mind_q;
    flags_d    = flags_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    char_o     = CH_ZERO;
    last_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          flags_d  = flags_i;
          mind_d   = mind_i;
          seen_d   = 1'b0;
          cnt_d    = '0;
          sh_d     = SH_W'(mag_i);
          pos_d    = (mind_i > MIND_W'(NDIG)) ? POS_W'(mind_i - MIND_W'(1))
                                              : POS_W'(NDIG - 1);
          unique case (flags_i.base)
            BASE_OCT: begin
              dig_d   = oct_dig;
              state_d = after_conv(flags_i);
            end
            BASE_DEC: begin
              dig_d   = '0;
              state_d = ST_CONV;
            end
            default: begin
              dig_d   = ext;
              state_d = after_conv(flags_i);
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_d = dabble(dabble(dig_q, sh_q[SH_W-1]), sh_q[SH_W-2]);
        sh_d  = {sh_q[SH_W-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          state_d = after_conv(flags_q);
        end
      end
      ST_SIGN: begin
        char_o     = CH_MINUS;
        out_push_o = !out_full_i;
        if (!out_full_i) begin
          state_d = (flags_q.show_prefix && (flags_q.base != BASE_DEC)) ? ST_PFX0 : ST_DIGIT;
        end
      end
      ST_PFX0: begin
        char_o     = CH_ZERO;
        out_push_o = !out_full_i;
        if (!out_full_i) begin
          state_d = (flags_q.base == BASE_HEX) ? ST_PFXX : ST_DIGIT;
        end
      end
      ST_PFXX: begin
        char_o     = flags_q.upper ? CH_X_UP : CH_X_LO;
        out_push_o = !out_full_i;
        if (!out_full_i) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        char_o = lead ? pad_char : digit_char(cur_dig, flags_q.upper);
        last_o = (pos_q == '0);
        if (skip) begin
          pos_d = pos_q - 1'b1;
        end else if (!out_full_i) begin
          out_push_o = 1'b1;
          if (!cur_zero) begin
            seen_d = 1'b1;
          end
          if (pos_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    sh_q    <= sh_d;
    mind_q  <= mind_d;
    flags_q <= flags_d;
  end

endmodule

@@ dv/integer_to_ascii_radix_formatter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to ASCII radix formatter: self-checking testbench
// Offers numbers through the push/full queue port, first from a short table of
// corner cases, then at random. The table's text, or a behavioural formatter
// where a row has none, predicts the character words of each number, and
// every popped word is compared with them in order. Both sides idle at random,
// the receiver holds off once to fill the block, and the sender drains it twice.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_formatter_unit_tb;

  import itarf_pkg::*;

  localparam int unsigned MAX_DIG     = MAX_DIGITS_DEF;
  localparam logic [1:0]  BSEL_SPARE  = 2'd3;
  localparam int unsigned N_RANDOM    = 95;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 150;

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic [1:0]  base_sel;
    logic [4:0]  min_digits;
    logic        pad_zero;
    logic        show_prefix;
    logic        uppercase;
  } num_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    num_word_t w;
    string     want;
  } vec_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push_i        = 1'b0;
  logic        full_o;
  logic [63:0] value_i       = '0;
  logic        is_signed_i   = 1'b0;
  logic [1:0]  base_sel_i    = BSEL_OCT;
  logic [4:0]  min_digits_i  = '0;
  logic        pad_zero_i    = 1'b0;
  logic        show_prefix_i = 1'b0;
  logic        uppercase_i   = 1'b0;
  logic        empty_o;
  logic        pop_i         = 1'b0;
  logic [7:0]  char_out_o;
  logic        last_char_o;

  logic        hold_req      = 1'b0;

  char_word_t  pending_chars[$];
  vec_row_t    vec_rows[$];
  int unsigned mismatches    = 0;
  int unsigned chars_checked = 0;
  int unsigned numbers_sent  = 0;
  int unsigned full_stalls   = 0;
  int unsigned burst_left    = 0;

  integer_to_ascii_radix_formatter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .value_i       (value_i),
    .is_signed_i   (is_signed_i),
    .base_sel_i    (base_sel_i),
    .min_digits_i  (min_digits_i),
    .pad_zero_i    (pad_zero_i),
    .show_prefix_i (show_prefix_i),
    .uppercase_i   (uppercase_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .char_out_o    (char_out_o),
    .last_char_o   (last_char_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic num_word_t mk(input logic [63:0] v, input logic sgn,
                                   input logic [1:0] bsel, input logic [4:0] mind,
                                   input logic pz, input logic pf, input logic up);
    num_word_t w;
    w = '{value: v, is_signed: sgn, base_sel: bsel, min_digits: mind,
          pad_zero: pz, show_prefix: pf, uppercase: up};
    return w;
  endfunction

  // Characters of one number, sign first, then prefix, then padded digits.
  function automatic text_q_t format_number(input num_word_t w);
    text_q_t     txt;
    logic [7:0]  rev [0:63];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] d;
    int unsigned ndig;
    int unsigned width;
    mag  = w.value;
    ndig = 0;
    if (w.is_signed && w.value[63]) begin
      txt.push_back(CH_MINUS);
      mag = -w.value;
    end
    case (w.base_sel)
      BSEL_OCT: radix = 64'd8;
      BSEL_DEC: radix = 64'd10;
      default:  radix = 64'd16;   // the spare code formats as hexadecimal
    endcase
    if (w.show_prefix && radix != 64'd10) begin
      txt.push_back(CH_ZERO);
      if (radix == 64'd16) begin
        txt.push_back(w.uppercase ? CH_X_UP : CH_X_LO);
      end
    end
    do begin
      d = mag % radix;
      if (d < 64'd10) begin
        rev[ndig] = CH_ZERO + d[7:0];
      end else begin
        rev[ndig] = (w.uppercase ? CH_A_UP : CH_A_LO) + d[7:0] - 8'd10;
      end
      ndig++;
      mag = mag / radix;
    end while (mag != 64'd0);
    width = (w.min_digits > MAX_DIG) ? MAX_DIG : w.min_digits;
    while (ndig < width) begin
      rev[ndig] = w.pad_zero ? CH_ZERO : CH_SPACE;
      ndig++;
    end
    for (int i = int'(ndig) - 1; i >= 0; i--) begin
      txt.push_back(rev[i]);
    end
    return txt;
  endfunction

  function automatic void await_text(input text_q_t txt);
    foreach (txt[i]) begin
      pending_chars.push_back('{ch: txt[i], last: (i == txt.size() - 1)});
    end
  endfunction

  function automatic num_word_t rand_number();
    num_word_t   w;
    logic [63:0] v;
    int unsigned k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 5))
      0:       v = {$urandom, $urandom};
      1:       v = 64'($urandom_range(0, 999));
      2:       v = -64'($urandom_range(1, 999));
      3:       v = $urandom_range(0, 1) ? (64'd1 << k) : ~(64'd1 << k);
      4:       v = $urandom_range(0, 1) ? {1'b1, 63'd0} : {64{$urandom_range(0, 1) == 1}};
      default: v = {$urandom, $urandom} >> k;
    endcase
    w = mk(v, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
           ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(0, 12)),
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
    return w;
  endfunction

  // The sender works in bursts, most of them preceded by a gap with push low.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  // Holds the word on the port until it is taken, then queues its characters.
  task automatic offer_number(input num_word_t w, input string want);
    text_q_t txt;
    push_i        <= 1'b1;
    value_i       <= w.value;
    is_signed_i   <= w.is_signed;
    base_sel_i    <= w.base_sel;
    min_digits_i  <= w.min_digits;
    pad_zero_i    <= w.pad_zero;
    show_prefix_i <= w.show_prefix;
    uppercase_i   <= w.uppercase;
    forever begin
      @(posedge clk_i);
      if (push_i && !full_o) break;
      if (push_i && full_o) full_stalls++;
    end
    if (want.len() > 0) begin
      for (int i = 0; i < want.len(); i++) txt.push_back(want[i]);
    end else begin
      txt = format_number(w);
    end
    await_text(txt);
    numbers_sent++;
  endtask

  task automatic note_mismatch(input string what, input logic [8:0] want_w,
                               input logic [8:0] got_w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch on character %0d: expected %h, got %h",
               $realtime, what, chars_checked, want_w, got_w);
    end
  endtask

  task automatic check_char();
    char_word_t want_c;
    if (pending_chars.size() == 0) begin
      note_mismatch("unexpected word", 9'h0, {char_out_o, last_char_o});
    end else begin
      want_c = pending_chars.pop_front();
      if (char_out_o !== want_c.ch) begin
        note_mismatch("char_out", {1'b0, want_c.ch}, {1'b0, char_out_o});
      end
      if (last_char_o !== want_c.last) begin
        note_mismatch("last_char", {8'h0, want_c.last}, {8'h0, last_char_o});
      end
    end
    chars_checked++;
  endtask

  initial begin : receiver
    logic [15:0] pat;
    logic [5:0]  ph;
    bit          held;
    pat  = '0;
    ph   = '0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) check_char();
      if (ph == 6'd0) begin
        case ($urandom_range(0, 2))
          0:       pat = '0;
          1:       pat = 16'($urandom);
          default: pat = 16'($urandom & $urandom);
        endcase
      end
      ph++;
      if (hold_req && !held) begin
        // Long hold-off so that both queues fill and push is refused.
        held = 1;
        pop_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pop_i <= !pat[ph[3:0]];
    end
  end

  initial begin : sender
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    vec_rows.push_back('{mk(64'd0, 1'b0, BSEL_DEC, 5'd0, 1'b0, 1'b0, 1'b0), "0"});
    vec_rows.push_back('{mk(64'd0, 1'b0, BSEL_OCT, 5'd0, 1'b0, 1'b1, 1'b0), "00"});
    vec_rows.push_back('{mk(64'd0, 1'b1, BSEL_HEX, 5'd0, 1'b0, 1'b1, 1'b0), "0x0"});
    vec_rows.push_back('{mk('1, 1'b0, BSEL_HEX, 5'd0, 1'b0, 1'b1, 1'b1),
                         "0XFFFFFFFFFFFFFFFF"});
    vec_rows.push_back('{mk('1, 1'b0, BSEL_DEC, 5'd0, 1'b1, 1'b1, 1'b0),
                         "18446744073709551615"});
    vec_rows.push_back('{mk('1, 1'b1, BSEL_DEC, 5'd0, 1'b0, 1'b0, 1'b0), "-1"});
    vec_rows.push_back('{mk({1'b1, 63'd0}, 1'b1, BSEL_DEC, 5'd0, 1'b0, 1'b0, 1'b0),
                         "-9223372036854775808"});
    vec_rows.push_back('{mk('1, 1'b0, BSEL_OCT, 5'd0, 1'b0, 1'b1, 1'b0), ""});
    vec_rows.push_back('{mk(64'd42, 1'b0, BSEL_DEC, 5'd5, 1'b1, 1'b0, 1'b0), "00042"});
    vec_rows.push_back('{mk(64'd42, 1'b0, BSEL_DEC, 5'd5, 1'b0, 1'b0, 1'b0), "   42"});
    vec_rows.push_back('{mk(64'd42, 1'b0, BSEL_OCT, 5'd0, 1'b0, 1'b1, 1'b0), "052"});
    vec_rows.push_back('{mk(64'hab, 1'b0, BSEL_HEX, 5'd6, 1'b0, 1'b1, 1'b0), "0x    ab"});
    vec_rows.push_back('{mk(64'hab, 1'b0, BSEL_HEX, 5'd6, 1'b1, 1'b1, 1'b1), "0X0000AB"});
    vec_rows.push_back('{mk(64'd255, 1'b0, BSEL_SPARE, 5'd0, 1'b0, 1'b0, 1'b1), "FF"});
    vec_rows.push_back('{mk(64'd7, 1'b0, BSEL_DEC, 5'd0, 1'b0, 1'b1, 1'b1), "7"});
    vec_rows.push_back('{mk(64'd123456, 1'b0, BSEL_DEC, 5'd3, 1'b1, 1'b0, 1'b0), "123456"});
    vec_rows.push_back('{mk(-64'd255, 1'b1, BSEL_HEX, 5'd4, 1'b1, 1'b1, 1'b0), "-0x00ff"});
    vec_rows.push_back('{mk(-64'd8, 1'b1, BSEL_OCT, 5'd0, 1'b0, 1'b0, 1'b0), "-10"});
    vec_rows.push_back('{mk(64'd100, 1'b1, BSEL_DEC, 5'd0, 1'b0, 1'b0, 1'b0), "100"});
    vec_rows.push_back('{mk(64'hfedcba9876543210, 1'b0, BSEL_HEX, 5'd0, 1'b0, 1'b1, 1'b1),
                         "0XFEDCBA9876543210"});
    vec_rows.push_back('{mk(64'h0123456789abcdef, 1'b0, BSEL_HEX, 5'd0, 1'b0, 1'b0, 1'b0),
                         "123456789abcdef"});
    // Minimum counts of 30 and above; the last row gives the longest number.
    vec_rows.push_back('{mk(64'd5, 1'b0, BSEL_DEC, 5'd31, 1'b1, 1'b0, 1'b0), ""});
    vec_rows.push_back('{mk(64'd0, 1'b1, BSEL_DEC, 5'd30, 1'b0, 1'b0, 1'b0), ""});
    vec_rows.push_back('{mk({1'b1, 63'd0}, 1'b1, BSEL_OCT, 5'd31, 1'b0, 1'b1, 1'b0), ""});
    vec_rows.push_back('{mk('1, 1'b1, BSEL_HEX, 5'd31, 1'b1, 1'b1, 1'b1), ""});

    foreach (vec_rows[i]) begin
      pace_sender();
      offer_number(vec_rows[i].w, vec_rows[i].want);
    end

    // Let the block run dry before the random part starts.
    push_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 10) hold_req <= 1'b1;
      pace_sender();
      offer_number(rand_number(), "");
    end

    push_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d numbers (%0d from the corner table), %0d characters checked,",
             numbers_sent, vec_rows.size(), chars_checked);
    $display("with push refused by a full block on %0d cycles.", full_stalls);
    if (mismatches == 0) begin
      $display("integer_to_ascii_radix_formatter_unit test passed");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("integer_to_ascii_radix_formatter_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Run timed out with %0d characters still awaited.", pending_chars.size());
    $display("integer_to_ascii_radix_formatter_unit test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/itarf_pkg.sv
sv/itarf_fifo.sv
sv/itarf_front.sv
sv/itarf_back.sv
sv/integer_to_ascii_radix_formatter_unit.sv
dv/integer_to_ascii_radix_formatter_unit_tb.sv
